@@ design/smooth_vertex_normal_builder_defines.svh @@
// ---------------------------------------------------------------------------
// Smooth vertex normal builder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SMOOTH_VERTEX_NORMAL_BUILDER_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_BUILDER_DEFINES_SVH

// same-cycle implication
`define SVNB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVNB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/svnb_pkg.sv @@
// ---------------------------------------------------------------------------
// svnb_pkg
// Types, constants and helpers shared by the smooth vertex normal builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svnb_pkg;

    localparam int VERT_AW  = 10;
    localparam int NUM_VERT = 1 << VERT_AW;
    localparam int SRC_AW   = 10;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;

    localparam logic signed [15:0] UNIT_MAX = 16'sd32767;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [10:0] source_index;
        logic [9:0]         vert_a;
        logic [9:0]         vert_b;
        logic [9:0]         vert_c;
    } req_t;

    typedef struct packed {
        logic               start;
        logic signed [36:0] vx;
        logic signed [36:0] vy;
        logic signed [36:0] vz;
    } norm_req_t;

    typedef struct packed {
        logic               done;
        logic               nonzero;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } norm_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_TRD,
        S_TCAP,
        S_TMUL,
        S_TNST,
        S_TNORM,
        S_TACC,
        S_TVS,
        S_TSS,
        S_QRD,
        S_QLK,
        S_QSEL,
        S_QNORM,
        S_QOUT
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DPREP,
        N_DIV,
        N_FIN
    } norm_state_t;

    function automatic logic link_ok(input logic signed [10:0] s, input logic [10:0] cnt);
        return !s[10] && ({1'b0, s[9:0]} < cnt);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [15:0] b);
        logic [32:0] t;
        t = {a[31], a} + {{17{b[15]}}, b};
        if (t[32] != t[31])
        begin
            return t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return t[31:0];
    endfunction

    function automatic logic [95:0] sat_add3(input logic [95:0] s, input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [15:0] z);
        return {sat_add(s[95:64], z), sat_add(s[63:32], y), sat_add(s[31:0], x)};
    endfunction

endpackage

`default_nettype wire

@@ design/svnb_front.sv @@
// ---------------------------------------------------------------------------
// svnb_front
// Request intake: decodes the stream request and queues it for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svnb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          q_valid,
    output svnb_pkg::req_t q_entry,
    input  logic          q_pop
);
    import svnb_pkg::*;

    req_t           buf_reg [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;
    req_t           dec;
    logic           push;

    always_comb
    begin
        dec.cmd          = cmd_t'(s_tuser);
        dec.pos_x        = s_tdata[15:0];
        dec.pos_y        = s_tdata[31:16];
        dec.pos_z        = s_tdata[47:32];
        dec.source_index = s_tdata[58:48];
        dec.vert_a       = s_tdata[68:59];
        dec.vert_b       = s_tdata[78:69];
        dec.vert_c       = s_tdata[88:79];
    end

    assign s_tready = (cnt_reg != (QAW+1)'(QDEPTH)) && !hold;
    // unused command code is taken and dropped
    assign push     = s_tvalid && s_tready && (dec.cmd != CMD_NONE);
    assign q_valid  = (cnt_reg != '0);
    assign q_entry  = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/svnb_norm.sv @@
// ---------------------------------------------------------------------------
// svnb_norm
// Iterative Q1.15 vector normalizer: range shift, sum of squares, bit-pair
// square root and three restoring divides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svnb_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  svnb_pkg::norm_req_t req,
    output svnb_pkg::norm_rsp_t rsp
);
    import svnb_pkg::*;

    norm_state_t state_reg, state_next;

    logic [35:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [35:0] mx_reg;
    logic        nz_reg;
    logic [1:0]  sq_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] s_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [47:0] num_reg [3];
    logic [31:0] rem_reg [3];
    logic [16:0] q_reg [3];
    logic [4:0]  dv_reg;

    logic signed [36:0] vin [3];
    logic [36:0]        av  [3];
    logic [35:0]        mx_in;
    logic [63:0]        rb;
    logic [31:0]        sq_op;
    logic [47:0]        num_in [3];
    logic [32:0]        t   [3];
    logic               ge  [3];
    logic [15:0]        qs  [3];
    logic signed [15:0] nout [3];

    assign vin[0] = req.vx;
    assign vin[1] = req.vy;
    assign vin[2] = req.vz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            av[i] = vin[i][36] ? 37'(-vin[i]) : vin[i];
        end
        mx_in = av[0][35:0];
        if (av[1][35:0] > mx_in)
        begin
            mx_in = av[1][35:0];
        end
        if (av[2][35:0] > mx_in)
        begin
            mx_in = av[2][35:0];
        end
    end

    assign rb    = r_reg + bit_reg;
    assign sq_op = (sq_reg == 2'd0) ? m_reg[0][31:0] :
                   (sq_reg == 2'd1) ? m_reg[1][31:0] : m_reg[2][31:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_in[i] = {1'b0, m_reg[i][31:0], 15'd0} + {17'd0, r_reg[31:1]};
            t[i]    = {rem_reg[i], num_reg[i][16]};
            ge[i]   = t[i] >= {1'b0, r_reg[31:0]};
            qs[i]   = (q_reg[i] > 17'd32767) ? UNIT_MAX : q_reg[i][15:0];
            nout[i] = neg_reg[i] ? -$signed(qs[i]) : $signed(qs[i]);
        end
    end

    assign rsp.done    = (state_reg == N_FIN);
    assign rsp.nonzero = nz_reg;
    assign rsp.nx      = nout[0];
    assign rsp.ny      = nout[1];
    assign rsp.nz      = nout[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (mx_in == '0) ? N_FIN : N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (mx_reg <= 36'h0_8000_0000 && mx_reg >= 36'h0_4000_0000)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (sq_reg == 2'd3)
                begin
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if (bit_reg == 64'd1)
                begin
                    state_next = N_DPREP;
                end
            end
            N_DPREP:
            begin
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (dv_reg == 5'd16)
                begin
                    state_next = N_FIN;
                end
            end
            N_FIN:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                // result stays valid until the next start
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]   <= av[i][35:0];
                        neg_reg[i] <= vin[i][36];
                    end
                    mx_reg <= mx_in;
                    nz_reg <= (mx_in != '0);
                    sq_reg <= '0;
                end
            end
            N_SHIFT:
            begin
                if (mx_reg > 36'h0_8000_0000)
                begin
                    mx_reg <= mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
                else if (mx_reg < 36'h0_4000_0000)
                begin
                    mx_reg <= mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            N_SQ:
            begin
                sq_reg   <= sq_reg + 1'b1;
                prod_reg <= sq_op * sq_op;
                if (sq_reg == 2'd1)
                begin
                    acc_reg <= prod_reg;
                end
                else if (sq_reg == 2'd2)
                begin
                    acc_reg <= acc_reg + prod_reg;
                end
                s_reg   <= acc_reg + prod_reg;
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            N_SQRT:
            begin
                if (s_reg >= rb)
                begin
                    s_reg <= s_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DPREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i] <= num_in[i];
                    rem_reg[i] <= {1'b0, num_in[i][47:17]};
                    q_reg[i]   <= '0;
                end
                dv_reg <= '0;
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= ge[i] ? 32'(t[i] - {1'b0, r_reg[31:0]}) : t[i][31:0];
                    q_reg[i]   <= {q_reg[i][15:0], ge[i]};
                    num_reg[i] <= num_reg[i] << 1;
                end
                dv_reg <= dv_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/svnb_back.sv @@
// ---------------------------------------------------------------------------
// svnb_back
// Command sequencer: vertex and source stores, cross product, sum updates
// and query result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svnb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [10:0]         source_count,
    input  logic                q_valid,
    input  svnb_pkg::req_t      q_entry,
    output logic                q_pop,
    output logic                clearing,
    output svnb_pkg::norm_req_t norm_req,
    input  svnb_pkg::norm_rsp_t norm_rsp,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,
    output logic                m_tuser
);
    import svnb_pkg::*;

    back_state_t state_reg, state_next;
    req_t        cur_reg;
    logic [VERT_AW-1:0] clr_reg;
    logic [1:0]  k_reg;
    logic [2:0]  mul_reg;
    logic [47:0] p_reg [3];
    logic signed [33:0] prod_reg;
    logic signed [34:0] acc_reg;
    logic signed [34:0] cr_reg [3];

    logic [47:0] pos_mem [NUM_VERT];
    logic [10:0] link_mem [NUM_VERT];
    logic [95:0] vsum_mem [NUM_VERT];
    logic [95:0] ssum_mem [NUM_VERT];
    logic [47:0] pos_rd_reg;
    logic [10:0] link_rd_reg;
    logic [95:0] vsum_rd_reg;
    logic [95:0] ssum_rd_reg;

    logic               pos_re, pos_we, link_re, link_we;
    logic               vsum_re, vsum_we, ssum_re, ssum_we;
    logic [VERT_AW-1:0] pos_ra, vsum_ra, vsum_wa;
    logic [SRC_AW-1:0]  ssum_ra, ssum_wa;
    logic [95:0]        vsum_wd, ssum_wd;

    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_user_reg;
    logic               out_load;

    logic [VERT_AW-1:0] corner;
    logic signed [16:0] e1 [3];
    logic signed [16:0] e2 [3];
    logic signed [16:0] opa, opb;
    logic [95:0]        qvec;
    logic [2:0]         mj;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner = cur_reg.vert_a;
            2'd1:    corner = cur_reg.vert_b;
            default: corner = cur_reg.vert_c;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = $signed({p_reg[1][16*i+15], p_reg[1][16*i +: 16]})
                  - $signed({p_reg[0][16*i+15], p_reg[0][16*i +: 16]});
            e2[i] = $signed({p_reg[2][16*i+15], p_reg[2][16*i +: 16]})
                  - $signed({p_reg[0][16*i+15], p_reg[0][16*i +: 16]});
        end
        case (mul_reg)
            3'd0:    begin opa = e1[1]; opb = e2[2]; end
            3'd1:    begin opa = e1[2]; opb = e2[1]; end
            3'd2:    begin opa = e1[2]; opb = e2[0]; end
            3'd3:    begin opa = e1[0]; opb = e2[2]; end
            3'd4:    begin opa = e1[0]; opb = e2[1]; end
            3'd5:    begin opa = e1[1]; opb = e2[0]; end
            default: begin opa = '0;    opb = '0;    end
        endcase
    end

    assign mj   = mul_reg - 3'd1;
    assign qvec = link_ok(link_rd_reg, source_count) ? ssum_rd_reg : vsum_rd_reg;

    always_comb
    begin
        norm_req.start = 1'b0;
        norm_req.vx    = {{2{cr_reg[0][34]}}, cr_reg[0]};
        norm_req.vy    = {{2{cr_reg[1][34]}}, cr_reg[1]};
        norm_req.vz    = {{2{cr_reg[2][34]}}, cr_reg[2]};
        if (state_reg == S_QSEL)
        begin
            norm_req.vx = {{5{qvec[31]}}, qvec[31:0]};
            norm_req.vy = {{5{qvec[63]}}, qvec[63:32]};
            norm_req.vz = {{5{qvec[95]}}, qvec[95:64]};
        end
        if (state_reg == S_QSEL || state_reg == S_TNST)
        begin
            norm_req.start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        pos_re     = 1'b0;
        pos_we     = 1'b0;
        link_re    = 1'b0;
        link_we    = 1'b0;
        vsum_re    = 1'b0;
        vsum_we    = 1'b0;
        ssum_re    = 1'b0;
        ssum_we    = 1'b0;
        pos_ra     = corner;
        vsum_ra    = corner;
        vsum_wa    = corner;
        vsum_wd    = sat_add3(vsum_rd_reg, norm_rsp.nx, norm_rsp.ny, norm_rsp.nz);
        ssum_ra    = link_rd_reg[SRC_AW-1:0];
        ssum_wa    = link_rd_reg[SRC_AW-1:0];
        ssum_wd    = sat_add3(ssum_rd_reg, norm_rsp.nx, norm_rsp.ny, norm_rsp.nz);
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                vsum_we = 1'b1;
                ssum_we = 1'b1;
                vsum_wa = clr_reg;
                ssum_wa = clr_reg;
                vsum_wd = '0;
                ssum_wd = '0;
                if (clr_reg == VERT_AW'(NUM_VERT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.cmd)
                        CMD_LOAD:  state_next = S_LOAD;
                        CMD_TRI:   state_next = S_TRD;
                        CMD_QUERY: state_next = S_QRD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                pos_we  = 1'b1;
                link_we = 1'b1;
                vsum_we = 1'b1;
                vsum_wa = cur_reg.vert_a;
                vsum_wd = '0;
                ssum_we = link_ok(cur_reg.source_index, source_count);
                ssum_wa = cur_reg.source_index[SRC_AW-1:0];
                ssum_wd = '0;
                state_next = S_IDLE;
            end
            S_TRD:
            begin
                pos_re     = 1'b1;
                state_next = S_TCAP;
            end
            S_TCAP:
            begin
                state_next = (k_reg == 2'd2) ? S_TMUL : S_TRD;
            end
            S_TMUL:
            begin
                if (mul_reg == 3'd6)
                begin
                    state_next = S_TNST;
                end
            end
            S_TNST:
            begin
                state_next = S_TNORM;
            end
            S_TNORM:
            begin
                if (norm_rsp.done)
                begin
                    state_next = norm_rsp.nonzero ? S_TACC : S_IDLE;
                end
            end
            S_TACC:
            begin
                vsum_re    = 1'b1;
                link_re    = 1'b1;
                state_next = S_TVS;
            end
            S_TVS:
            begin
                vsum_we = 1'b1;
                if (link_ok(link_rd_reg, source_count))
                begin
                    ssum_re    = 1'b1;
                    state_next = S_TSS;
                end
                else
                begin
                    state_next = (k_reg == 2'd2) ? S_IDLE : S_TACC;
                end
            end
            S_TSS:
            begin
                ssum_we    = 1'b1;
                state_next = (k_reg == 2'd2) ? S_IDLE : S_TACC;
            end
            S_QRD:
            begin
                vsum_re    = 1'b1;
                link_re    = 1'b1;
                vsum_ra    = cur_reg.vert_a;
                state_next = S_QLK;
            end
            S_QLK:
            begin
                ssum_re    = 1'b1;
                state_next = S_QSEL;
            end
            S_QSEL:
            begin
                state_next = S_QNORM;
            end
            S_QNORM:
            begin
                if (norm_rsp.done)
                begin
                    state_next = S_QOUT;
                end
            end
            S_QOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign clearing = (state_reg == S_CLEAR);

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[cur_reg.vert_a] <= {cur_reg.pos_z, cur_reg.pos_y, cur_reg.pos_x};
        end
        if (pos_re)
        begin
            pos_rd_reg <= pos_mem[pos_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[cur_reg.vert_a] <= cur_reg.source_index;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[vsum_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vsum_we)
        begin
            vsum_mem[vsum_wa] <= vsum_wd;
        end
        if (vsum_re)
        begin
            vsum_rd_reg <= vsum_mem[vsum_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ssum_we)
        begin
            ssum_mem[ssum_wa] <= ssum_wd;
        end
        if (ssum_re)
        begin
            ssum_rd_reg <= ssum_mem[ssum_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
        if (state_reg == S_TCAP)
        begin
            p_reg[k_reg] <= pos_rd_reg;
        end
        if (state_reg == S_TMUL)
        begin
            prod_reg <= opa * opb;
            if (mul_reg != 3'd0)
            begin
                if (!mj[0])
                begin
                    acc_reg <= {prod_reg[33], prod_reg};
                end
                else
                begin
                    cr_reg[mj[2:1]] <= acc_reg - {prod_reg[33], prod_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            k_reg         <= '0;
            mul_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_IDLE || state_reg == S_TMUL)
            begin
                k_reg <= '0;
            end
            else if (state_reg == S_TCAP
                     || ((state_reg == S_TVS || state_reg == S_TSS) && state_next == S_TACC))
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == S_TMUL)
            begin
                mul_reg <= mul_reg + 1'b1;
            end
            else
            begin
                mul_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_user_reg  <= !norm_rsp.nonzero;
                if (norm_rsp.nonzero)
                begin
                    out_data_reg <= {6'd0, norm_rsp.nz, norm_rsp.ny, norm_rsp.nx,
                                     cur_reg.vert_a};
                end
                else
                begin
                    out_data_reg <= {6'd0, 16'd0, UNIT_MAX, 16'd0, cur_reg.vert_a};
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

@@ design/smooth_vertex_normal_builder.sv @@
// Smooth vertex normal builder. After reset the block runs a clearing pass over
// the vertex and source sum stores and takes no request until it ends. Requests
// enter a four-deep queue and are worked one at a time. A triangle whose cross
// product is zero, or a query of a zero sum, skips the normalizer's steps: a
// range shift of up to about 30 one-bit steps, squaring, a 32-step square root
// and a 17-step divide. A query result sits in an output register, so the
// queue keeps filling while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module smooth_vertex_normal_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z, source_index, vert_a, vert_b, vert_c
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // vert_idx, normal_x, normal_y, normal_z
    output logic        m_tuser,   // used_default
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import svnb_pkg::*;

    logic [10:0] source_count_reg;
    logic        clearing;
    logic        q_valid;
    logic        q_pop;
    req_t        q_entry;
    norm_req_t   norm_req;
    norm_rsp_t   norm_rsp;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {21'd0, source_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= 11'd1024;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            source_count_reg <= pwdata[10:0];
        end
    end

    svnb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    svnb_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

    svnb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_count (source_count_reg),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .norm_req     (norm_req),
        .norm_rsp     (norm_rsp),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

`default_nettype wire

@@ design/svnb_checker.sv @@
// ---------------------------------------------------------------------------
// svnb_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "smooth_vertex_normal_builder_defines.svh"

module svnb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    `SVNB_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SVNB_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `SVNB_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[63:58] == 6'd0, "result padding not zero")
    `SVNB_ASSERT_SAME(a_default_up, m_tvalid && m_tuser, m_tdata[25:10] == 16'd0 && m_tdata[41:26] == 16'h7fff && m_tdata[57:42] == 16'd0, "default result is not the up vector")

endmodule

bind smooth_vertex_normal_builder svnb_checker u_svnb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ test/tb_smooth_vertex_normal_builder.sv @@
// ---------------------------------------------------------------------------
// tb_smooth_vertex_normal_builder
// Streams load, triangle and query requests into the normal builder under
// several source_count settings. A local fixed-point model accumulates the
// triangle normals and predicts every query result, checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_smooth_vertex_normal_builder;
    import svnb_pkg::*;

    typedef struct {
        logic [9:0]  vidx;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        dflt;
    } normal_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    req_t    pend_q[$];
    req_t    cur_req;
    normal_t normal_q[$];
    bit      sent = 1'b0;
    bit      idle_on = 1'b1;
    bit      long_hold_req = 1'b0;
    int      tx_gap = 0;
    int      rx_hold = 0;
    int      errors = 0;
    int      checked = 0;
    int      n_load = 0, n_tri = 0, n_query = 0;
    int      quiet = 0;

    // model state
    int          vpos[1024][3];
    int          vlink[1024];
    int          vsum[1024][3];
    int          ssum[1024][3];
    int unsigned src_cnt = 1024;

    // stimulus bookkeeping
    bit          loaded[1024];
    int          loaded_list[$];

    smooth_vertex_normal_builder u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic bit src_valid(int s);
        return s >= 0 && s < src_cnt && s < 1024;
    endfunction

    function automatic int sat32(int a, int b);
        longint t;
        t = longint'(a) + longint'(b);
        if (t > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (t < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return int'(t);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in Q1.15, returns 0 for a zero vector
    function automatic bit unit_q15(input longint v[3], output int n[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            return 1'b0;
        while (mx > (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sq = sq + m[i] * m[i];
        len = root64(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 64'd32768 + len / 2) / len;
            if (q > 32767)
                q = 32767;
            n[i] = v[i] < 0 ? -int'(q) : int'(q);
        end
        return 1'b1;
    endfunction

    task automatic apply_request(req_t r);
        int      a, b, c, s;
        int      cs[3];
        longint  e1[3], e2[3], cr[3];
        int      n[3];
        normal_t res;
        a = r.vert_a;
        case (r.cmd)
            CMD_LOAD:
            begin
                s = r.source_index;
                vpos[a][0] = r.pos_x;
                vpos[a][1] = r.pos_y;
                vpos[a][2] = r.pos_z;
                vlink[a] = s;
                for (int i = 0; i < 3; i++)
                    vsum[a][i] = 0;
                if (src_valid(s))
                    for (int i = 0; i < 3; i++)
                        ssum[s][i] = 0;
            end
            CMD_TRI:
            begin
                b = r.vert_b;
                c = r.vert_c;
                cs = '{a, b, c};
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = longint'(vpos[b][i]) - vpos[a][i];
                    e2[i] = longint'(vpos[c][i]) - vpos[a][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                if (unit_q15(cr, n))
                    for (int k = 0; k < 3; k++)
                    begin
                        s = vlink[cs[k]];
                        for (int i = 0; i < 3; i++)
                            vsum[cs[k]][i] = sat32(vsum[cs[k]][i], n[i]);
                        if (src_valid(s))
                            for (int i = 0; i < 3; i++)
                                ssum[s][i] = sat32(ssum[s][i], n[i]);
                    end
            end
            CMD_QUERY:
            begin
                s = vlink[a];
                for (int i = 0; i < 3; i++)
                    e1[i] = src_valid(s) ? ssum[s][i] : vsum[a][i];
                res.dflt = !unit_q15(e1, n);
                if (res.dflt)
                    n = '{0, 32767, 0};
                res.vidx = a[9:0];
                res.nx = n[0][15:0];
                res.ny = n[1][15:0];
                res.nz = n[2][15:0];
                normal_q.insert(normal_q.size(), res);
            end
            default:
            begin
            end
        endcase
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!s_tvalid || sent)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                cur_req = pend_q.pop_front();
                s_tdata <= {7'd0, cur_req.vert_c, cur_req.vert_b, cur_req.vert_a,
                            cur_req.source_index, cur_req.pos_z, cur_req.pos_y, cur_req.pos_x};
                s_tuser <= cur_req.cmd;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 18);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            rx_hold = 1500;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rx_hold = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // acceptance, prediction and checking
    always @(posedge clk)
    begin
        normal_t e;
        sent <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            apply_request(cur_req);
        if (m_tvalid && m_tready)
        begin
            if (normal_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = normal_q.pop_front();
                checked++;
                if (m_tdata[9:0] !== e.vidx || m_tdata[25:10] !== e.nx
                    || m_tdata[41:26] !== e.ny || m_tdata[57:42] !== e.nz
                    || m_tdata[63:58] !== 6'd0 || m_tuser !== e.dflt)
                begin
                    $display("%0t: vertex %0d expected n=(%0d,%0d,%0d) dflt=%b, actual %0d n=(%0d,%0d,%0d) dflt=%b",
                             $time, e.vidx, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.dflt,
                             m_tdata[9:0], $signed(m_tdata[25:10]), $signed(m_tdata[41:26]),
                             $signed(m_tdata[57:42]), m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= 20000)
        begin
            $display("smooth_vertex_normal_builder: mismatch");
            $finish;
        end
    end

    task automatic push_req(cmd_t cmd, int x, int y, int z, int src, int a, int b, int c);
        req_t r;
        r.cmd = cmd;
        r.pos_x = x[15:0];
        r.pos_y = y[15:0];
        r.pos_z = z[15:0];
        r.source_index = src[10:0];
        r.vert_a = a[9:0];
        r.vert_b = b[9:0];
        r.vert_c = c[9:0];
        if (cmd == CMD_LOAD)
        begin
            n_load++;
            if (!loaded[a[9:0]])
                loaded_list.insert(loaded_list.size(), int'(a[9:0]));
            loaded[a[9:0]] = 1'b1;
        end
        else if (cmd == CMD_TRI)
            n_tri++;
        else if (cmd == CMD_QUERY)
            n_query++;
        pend_q.insert(pend_q.size(), r);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 400) - 200;
        return int'($signed(16'($urandom())));
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    task automatic gen_random(int count);
        int r, src, slot;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (loaded_list.size() < 3)
                r = 10;
            if (r < 3)
            begin
                // unused command with noise
                push_req(CMD_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
            end
            else if (r < 28)
            begin
                r = $urandom_range(0, 9);
                src = r < 6 ? $urandom_range(0, 15) : (r < 8 ? -1 : $urandom_range(0, 1023));
                slot = $urandom_range(0, 3) != 0 ? $urandom_range(0, 63) : $urandom_range(0, 1023);
                push_req(CMD_LOAD, rand_coord(), rand_coord(), rand_coord(), src, slot,
                         $urandom(), $urandom());
            end
            else if (r < 70)
            begin
                push_req(CMD_TRI, $urandom(), $urandom(), $urandom(), $urandom(),
                         pick_loaded(), pick_loaded(), pick_loaded());
            end
            else
            begin
                push_req(CMD_QUERY, $urandom(), $urandom(), $urandom(), $urandom(),
                         pick_loaded(), $urandom(), $urandom());
            end
        end
    endtask

    task automatic wait_drained();
        wait (pend_q.size() == 0 && !s_tvalid && normal_q.size() == 0);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_count(int unsigned v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        src_cnt = v & 11'h7ff;
    endtask

    initial
    begin
        int unsigned counts[5];
        counts = '{1024, 0, 1, 7, 1024};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_count(1024);
        // directed
        push_req(CMD_LOAD, 0, 0, 0, -1, 0, 0, 0);
        push_req(CMD_LOAD, 32767, 0, 0, 0, 1, 0, 0);
        push_req(CMD_LOAD, 0, 32767, 0, 0, 2, 0, 0);
        push_req(CMD_LOAD, -32768, -32768, -32768, 1023, 1023, 0, 0);
        push_req(CMD_LOAD, 32767, -32768, 32767, 1023, 3, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 3, 0, 0);
        push_req(CMD_TRI, 0, 0, 0, 0, 0, 1, 2);
        push_req(CMD_TRI, 0, 0, 0, 0, 0, 0, 1);
        push_req(CMD_TRI, 0, 0, 0, 0, 1, 1, 1);
        push_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 1, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 1023, 0, 0);
        push_req(CMD_TRI, 0, 0, 0, 0, 1023, 3, 2);
        push_req(CMD_TRI, 0, 0, 0, 0, 3, 1023, 1);
        push_req(CMD_QUERY, 0, 0, 0, 0, 1023, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 3, 0, 0);
        push_req(CMD_NONE, -1, -1, -1, -1, 1023, 1023, 1023);
        push_req(CMD_LOAD, 5, 5, 5, 0, 2, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 1, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 2, 0, 0);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            write_count(counts[p]);
            if (p == 4)
                idle_on = 1'b0;
            gen_random(206);
            if (p == 1)
            begin
                repeat (200) @(posedge clk);
                long_hold_req = 1'b1;
            end
            wait_drained();
        end

        $display("Covered %0d loads, %0d triangles, %0d queries; %0d normals checked.",
                 n_load, n_tri, n_query, checked);
        $display("source_count settings: 1024, 0, 1, 7, 1024; long output stall included.");
        if (errors == 0)
            $display("smooth_vertex_normal_builder: match");
        else
            $display("smooth_vertex_normal_builder: mismatch");
        $finish;
    end

endmodule
